[hw/rtl/stu_pkg.sv]
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types, codes and constants of the surfactant tension update block.
// ----------------------------------------------------------------------------
package stu_pkg;

  localparam int FACE_COUNT = 1024;
  localparam int FACE_W     = $clog2(FACE_COUNT);
  localparam int CFG_IDX_W  = 3;

  localparam logic [30:0] Q_ONE = 31'd65536;

  localparam logic [1:0] ACT_TENSION = 2'd0;
  localparam logic [1:0] ACT_DERIV   = 2'd1;
  localparam logic [1:0] ACT_UPDATE  = 2'd2;
  localparam logic [1:0] ACT_SPARE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_NOT_SET  = 2'd2;

  localparam logic [1:0] RG_NONE     = 2'd0;
  localparam logic [1:0] RG_LANGMUIR = 2'd1;
  localparam logic [1:0] RG_MONO     = 2'd2;
  localparam logic [1:0] RG_COLLAPSE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ADS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TREF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEQ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHI  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TMIN = 3'd7;

  typedef struct packed {
    logic [1:0]        action;
    logic [FACE_W-1:0] face;
    logic [30:0]       area_new;
    logic signed [31:0] area_increment;
    logic [30:0]       inv_step;
    logic              in_startup;
  } stu_in_t;

  typedef struct packed {
    logic signed [31:0] tension;
    logic signed [31:0] tension_derivative;
    logic [1:0]         regime;
    logic [30:0]        concentration;
    logic [1:0]         status;
  } stu_out_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_RES, OP_STARTUP, OP_RD, OP_MUL_CA, OP_CA_NEXT,
    OP_P1, OP_P2, OP_DEN, OP_CLAMP, OP_TMUL, OP_TFIN, OP_A2_START, OP_A2_NEXT,
    OP_N1, OP_DEN2, OP_Q, OP_T, OP_DFIN, OP_WRITE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } stu_cmd_t;

  typedef struct packed {
    logic       mul_busy;
    logic       div_busy;
    logic       clr_last;
    logic       startup;
    logic [1:0] action;
    logic       entry_valid;
    logic       zero_div;
    logic       c_lt_one;
    logic       s_zero;
    logic [1:0] regime;
    logic       q_skip;
  } stu_sts_t;

endpackage

[hw/rtl/stu_in_if.sv]
// ----------------------------------------------------------------------------
// stu_in_if
// Request channel into the block: valid, ready and one request.
// ----------------------------------------------------------------------------
interface stu_in_if;
  import stu_pkg::*;
  logic    valid;
  logic    ready;
  stu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/stu_out_if.sv]
// ----------------------------------------------------------------------------
// stu_out_if
// Result channel out of the block: valid, ready and one result.
// ----------------------------------------------------------------------------
interface stu_out_if;
  import stu_pkg::*;
  logic     valid;
  logic     ready;
  stu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/stu_cfg_if.sv]
// ----------------------------------------------------------------------------
// stu_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface stu_cfg_if;
  import stu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/stu_mul.sv]
// ----------------------------------------------------------------------------
// stu_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module stu_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] a,
  input  logic [63:0]  b,
  output logic         busy,
  output logic [127:0] p
);
  logic [127:0] a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;
  logic         busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && b_r == 64'd0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && b_r != 64'd0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[126:0], 1'b0};
      b_r <= {1'b0, b_r[63:1]};
    end
  end

  assign busy = busy_r;
  assign p    = acc_r;
endmodule

[hw/rtl/stu_div.sv]
// ----------------------------------------------------------------------------
// stu_div
// Restoring divider, 128-bit dividend, 96-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module stu_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] n,
  input  logic [95:0]  d,
  output logic         busy,
  output logic [127:0] q
);
  logic [127:0] n_r;
  logic [95:0]  d_r;
  logic [95:0]  rem_r;
  logic [127:0] q_r;
  logic [6:0]   cnt_r;
  logic         busy_r;
  logic [96:0]  rem_sh;
  logic [96:0]  rem_sub;

  assign rem_sh  = {rem_r, n_r[127]};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd127) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n;
      d_r   <= d;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[126:0], 1'b0};
      if (rem_sh >= {1'b0, d_r}) begin
        rem_r <= rem_sub[95:0];
        q_r   <= {q_r[126:0], 1'b1};
      end else begin
        rem_r <= rem_sh[95:0];
        q_r   <= {q_r[126:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign q    = q_r;
endmodule

[hw/rtl/stu_datapath.sv]
// ----------------------------------------------------------------------------
// stu_datapath
// Face history memory, registers, shared multiplier and divider, and the
// tension and derivative arithmetic, driven one command per cycle.
// ----------------------------------------------------------------------------
module stu_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stu_pkg::stu_cmd_t             cmd,
  output stu_pkg::stu_sts_t             sts,
  input  stu_pkg::stu_in_t              in_data,
  output stu_pkg::stu_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [stu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                   cfg_data
);
  import stu_pkg::*;

  // entry: valid, concentration, area
  logic [62:0] mem [FACE_COUNT];
  logic [62:0] mem_q_r;

  stu_in_t            in_r;
  logic [30:0]        ads_r, des_r, cmax_r;
  logic signed [31:0] tref_r, teq_r, slo_r, shi_r, tmin_r;
  logic [32:0]        s_r;
  logic [61:0]        ca_r, a2_r;
  logic [127:0]       num_r;
  logic [30:0]        c_new_r;
  logic signed [63:0] prod_r;
  logic               zero_r, big_r;
  logic signed [31:0] tension_r, deriv_r;
  logic [1:0]         regime_r, status_r;
  logic [FACE_W-1:0]  clr_addr_r;

  logic               mul_start, div_start, mul_busy, div_busy;
  logic [127:0]       mul_a, mul_p, div_n, div_q;
  logic [63:0]        mul_b;
  logic [95:0]        div_d;
  logic [30:0]        c_old, a_old;
  logic signed [31:0] slope_sel;
  logic [31:0]        ms, md;
  logic               wr_en;
  logic [FACE_W-1:0]  wr_addr;
  logic [62:0]        wr_data;
  logic [1:0]         reg_nxt;
  logic [31:0]        x_nxt;
  logic signed [31:0] tension_nxt, deriv_nxt;
  logic [30:0]        c_clamp;

  assign c_old     = mem_q_r[61:31];
  assign a_old     = mem_q_r[30:0];
  assign slope_sel = (regime_r == RG_LANGMUIR) ? slo_r : shi_r;
  assign ms        = slope_sel[31] ? 32'(-slope_sel) : slope_sel;
  assign md        = in_r.area_increment[31] ? 32'(-in_r.area_increment)
                                             : in_r.area_increment;

  stu_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .p(mul_p)
  );

  stu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .n(div_n), .d(div_d),
    .busy(div_busy), .q(div_q)
  );

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd.op)
      OP_MUL_CA: begin
        mul_start = 1'b1;
        mul_a     = {97'd0, c_old};
        mul_b     = {33'd0, a_old};
      end
      OP_CA_NEXT: begin
        if (c_old < Q_ONE) begin
          mul_start = 1'b1;
          mul_a     = mul_p;
          mul_b     = {33'd0, in_r.inv_step};
        end else begin
          div_start = 1'b1;
          div_n     = mul_p;
          div_d     = {65'd0, in_r.area_new};
        end
      end
      OP_P1: begin
        mul_start = 1'b1;
        mul_a     = {97'd0, in_r.area_new};
        mul_b     = {33'd0, ads_r};
      end
      OP_P2: begin
        mul_start = 1'b1;
        mul_a     = {97'd0, in_r.area_new};
        mul_b     = {31'd0, s_r};
      end
      OP_DEN, OP_DEN2: begin
        div_start = 1'b1;
        div_n     = num_r;
        div_d     = mul_p[95:0];
      end
      OP_A2_START: begin
        mul_start = 1'b1;
        mul_a     = {97'd0, in_r.area_new};
        mul_b     = {33'd0, in_r.area_new};
      end
      OP_A2_NEXT: begin
        if (regime_r == RG_LANGMUIR) begin
          mul_start = 1'b1;
          mul_a     = {66'd0, ca_r};
          mul_b     = {33'd0, in_r.inv_step};
        end else begin
          div_start = 1'b1;
          div_n     = {50'd0, ca_r, 16'd0};
          div_d     = mul_p[95:0];
        end
      end
      OP_N1: begin
        mul_start = 1'b1;
        mul_a     = {66'd0, a2_r};
        mul_b     = {31'd0, s_r};
      end
      OP_Q: begin
        mul_start = 1'b1;
        mul_a     = {96'd0, ms};
        mul_b     = div_q[63:0];
      end
      OP_T: begin
        mul_start = 1'b1;
        mul_a     = mul_p;
        mul_b     = {32'd0, md};
      end
      default: begin
      end
    endcase
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = in_r.face;
    wr_data = {1'b1, c_new_r, in_r.area_new};
    case (cmd.op)
      OP_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
      end
      OP_STARTUP: begin
        wr_en   = 1'b1;
        wr_data = {1'b1, Q_ONE, in_r.area_new};
      end
      OP_WRITE: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD) begin
      mem_q_r <= mem[in_r.face];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ads_r  <= '0;
      des_r  <= '0;
      cmax_r <= Q_ONE;
      tref_r <= '0;
      teq_r  <= '0;
      slo_r  <= '0;
      shi_r  <= '0;
      tmin_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ADS:  ads_r  <= cfg_data[30:0];
        CFG_DES:  des_r  <= cfg_data[30:0];
        CFG_CMAX: cmax_r <= cfg_data[30:0];
        CFG_TREF: tref_r <= cfg_data;
        CFG_TEQ:  teq_r  <= cfg_data;
        CFG_SLO:  slo_r  <= cfg_data;
        CFG_SHI:  shi_r  <= cfg_data;
        CFG_TMIN: tmin_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // regime, tension, clamp and derivative arithmetic
  always_comb begin
    logic signed [63:0] sh;
    logic signed [48:0] diff;
    logic [63:0]        mag;
    logic               big;
    logic               neg;
    if (div_q[127:31] != '0 || div_q[30:0] > cmax_r) begin
      c_clamp = cmax_r;
    end else begin
      c_clamp = div_q[30:0];
    end
    if (c_new_r < Q_ONE) begin
      reg_nxt = RG_LANGMUIR;
      x_nxt   = {1'b0, c_new_r};
    end else if (c_new_r < cmax_r) begin
      reg_nxt = RG_MONO;
      x_nxt   = {1'b0, c_new_r - Q_ONE};
    end else begin
      reg_nxt = RG_COLLAPSE;
      x_nxt   = {1'b0, c_new_r - Q_ONE};
    end
    sh   = prod_r >>> 16;
    diff = 49'(((regime_r == RG_LANGMUIR) ? tref_r : teq_r)) - 49'($signed(sh[47:0]));
    if (regime_r == RG_COLLAPSE) begin
      tension_nxt = tmin_r;
    end else if (diff > 49'sd2147483647) begin
      tension_nxt = 32'sh7fffffff;
    end else if (diff < -49'sd2147483648) begin
      tension_nxt = 32'sh80000000;
    end else begin
      tension_nxt = diff[31:0];
    end
    mag = mul_p[95:32];
    big = big_r || (mul_p[127:96] != '0);
    neg = slope_sel[31] ^ in_r.area_increment[31];
    if (zero_r) begin
      deriv_nxt = '0;
    end else if (neg) begin
      deriv_nxt = (big || mag >= 64'h8000_0000) ? 32'sh80000000 : 32'(-mag);
    end else begin
      deriv_nxt = (big || mag > 64'h7fff_ffff) ? 32'sh7fffffff : mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        in_r      <= in_data;
        s_r       <= {2'b0, in_data.inv_step} + {2'b0, ads_r} + {2'b0, des_r};
        tension_r <= '0;
        deriv_r   <= '0;
        regime_r  <= RG_NONE;
        status_r  <= ST_OK;
        c_new_r   <= '0;
      end
      OP_RES: begin
        tension_r <= '0;
        deriv_r   <= '0;
        regime_r  <= RG_NONE;
        status_r  <= cmd.status;
        c_new_r   <= '0;
      end
      OP_STARTUP: c_new_r <= Q_ONE;
      OP_CA_NEXT: ca_r <= mul_p[61:0];
      OP_P1: num_r <= mul_p;
      OP_P2: num_r <= num_r + {mul_p[111:0], 16'd0};
      OP_CLAMP: c_new_r <= c_clamp;
      OP_TMUL: begin
        regime_r <= reg_nxt;
        prod_r   <= ((reg_nxt == RG_LANGMUIR) ? slo_r : shi_r) * $signed(x_nxt);
      end
      OP_TFIN: tension_r <= tension_nxt;
      OP_A2_NEXT: a2_r <= mul_p[61:0];
      OP_N1: num_r <= {mul_p[111:0], 16'd0};
      OP_Q: begin
        zero_r <= (slope_sel == '0) || (in_r.area_increment == '0) || (div_q == '0);
        big_r  <= div_q[127:64] != '0;
      end
      OP_DFIN: deriv_r <= deriv_nxt;
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.mul_busy    = mul_busy;
    sts.div_busy    = div_busy;
    sts.clr_last    = clr_addr_r == FACE_W'(FACE_COUNT - 1);
    sts.startup     = in_r.in_startup;
    sts.action      = in_r.action;
    sts.entry_valid = mem_q_r[62];
    sts.c_lt_one    = c_old < Q_ONE;
    sts.s_zero      = s_r == '0;
    sts.zero_div    = (in_r.area_new == '0) || ((c_old < Q_ONE) && (s_r == '0));
    sts.regime      = regime_r;
    sts.q_skip      = (slope_sel == '0) || (in_r.area_increment == '0) ||
                      (div_q == '0) || (div_q[127:64] != '0);
  end

  always_comb begin
    out_data.tension            = tension_r;
    out_data.tension_derivative = deriv_r;
    out_data.regime             = regime_r;
    out_data.concentration      = c_new_r;
    out_data.status             = status_r;
  end
endmodule

[hw/rtl/stu_ctrl.sv]
// ----------------------------------------------------------------------------
// stu_ctrl
// Sequencer: memory clearing pass, request dispatch and the step order of
// the concentration, tension and derivative computation.
// ----------------------------------------------------------------------------
module stu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output stu_pkg::stu_cmd_t cmd,
  input  stu_pkg::stu_sts_t sts
);
  import stu_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_CHK, S_WAIT, S_CA, S_P1, S_P2, S_DEN, S_CLAMP,
    S_TMUL, S_TFIN, S_DSEL, S_A2, S_N1, S_DEN2, S_Q, S_T, S_DFIN, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd.op     = OP_NONE;
    cmd.status = ST_OK;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        if (sts.action == ACT_SPARE) begin
          cmd.op = OP_RES;
        end else if (sts.startup) begin
          cmd.op = (sts.action == ACT_UPDATE) ? OP_STARTUP : OP_RES;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!sts.entry_valid) begin
          cmd.op     = OP_RES;
          cmd.status = ST_NOT_SET;
          state_nxt  = S_OUT;
        end else if (sts.zero_div) begin
          cmd.op     = OP_RES;
          cmd.status = ST_ZERO_DIV;
          state_nxt  = S_OUT;
        end else begin
          cmd.op    = OP_MUL_CA;
          ret_nxt   = S_CA;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!sts.mul_busy && !sts.div_busy) begin
          state_nxt = ret_r;
        end
      end
      S_CA: begin
        cmd.op    = OP_CA_NEXT;
        ret_nxt   = sts.c_lt_one ? S_P1 : S_CLAMP;
        state_nxt = S_WAIT;
      end
      S_P1: begin
        cmd.op    = OP_P1;
        ret_nxt   = S_P2;
        state_nxt = S_WAIT;
      end
      S_P2: begin
        cmd.op    = OP_P2;
        ret_nxt   = S_DEN;
        state_nxt = S_WAIT;
      end
      S_DEN: begin
        cmd.op    = OP_DEN;
        ret_nxt   = S_CLAMP;
        state_nxt = S_WAIT;
      end
      S_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_TFIN;
      end
      S_TFIN: begin
        cmd.op    = OP_TFIN;
        state_nxt = S_DSEL;
      end
      S_DSEL: begin
        if (sts.action == ACT_DERIV && sts.regime != RG_COLLAPSE) begin
          if (sts.regime == RG_LANGMUIR && sts.s_zero) begin
            cmd.op     = OP_RES;
            cmd.status = ST_ZERO_DIV;
            state_nxt  = S_OUT;
          end else begin
            cmd.op    = OP_A2_START;
            ret_nxt   = S_A2;
            state_nxt = S_WAIT;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_A2: begin
        cmd.op    = OP_A2_NEXT;
        ret_nxt   = (sts.regime == RG_LANGMUIR) ? S_N1 : S_Q;
        state_nxt = S_WAIT;
      end
      S_N1: begin
        cmd.op    = OP_N1;
        ret_nxt   = S_DEN2;
        state_nxt = S_WAIT;
      end
      S_DEN2: begin
        cmd.op    = OP_DEN2;
        ret_nxt   = S_Q;
        state_nxt = S_WAIT;
      end
      S_Q: begin
        cmd.op = OP_Q;
        if (sts.q_skip) begin
          state_nxt = S_DFIN;
        end else begin
          ret_nxt   = S_T;
          state_nxt = S_WAIT;
        end
      end
      S_T: begin
        cmd.op    = OP_T;
        ret_nxt   = S_DFIN;
        state_nxt = S_WAIT;
      end
      S_DFIN: begin
        cmd.op    = OP_DFIN;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.action == ACT_UPDATE) begin
          cmd.op = OP_WRITE;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
endmodule

[hw/rtl/surfactant_tension_update_core.sv]
// ----------------------------------------------------------------------------
// surfactant_tension_update_core
// Each division has a 128-bit dividend, and each multiply stops once its
// remaining multiplier bits are zero. One request at a time. The next one is
// taken the cycle after the result. Reset (synchronous, rst_n low) clears
// registers, then a clearing pass over all 1024 entries of the face memory
// runs with the request channel held not ready.
// ----------------------------------------------------------------------------
module surfactant_tension_update_core (
  input  logic      clk,
  input  logic      rst_n,
  stu_in_if.sink    in_ch,
  stu_out_if.source out_ch,
  stu_cfg_if.sink   cfg_ch
);
  import stu_pkg::*;

  stu_cmd_t cmd;
  stu_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  stu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd(cmd), .sts(sts)
  );

  stu_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_data(in_ch.data), .out_data(out_ch.data),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data)
  );
endmodule
